// ----- rtl/ftbpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ftbpp_pkg
// shared types, codes and helpers for the fasta two-bit plane packer
// ----------------------------------------------------------------------------
package ftbpp_pkg;

  localparam int COUNT_BITS = 40;
  localparam int OFFSET_W   = 40;
  localparam int CHAR_W     = 8;
  localparam int PLANE_W    = 8;
  localparam int FILL_W     = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // result kinds
  localparam logic [1:0] KIND_PAIR   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // characters of interest
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C       = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G       = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T       = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_N       = 8'h4E;
  localparam logic [CHAR_W-1:0] CHAR_HEADER  = 8'h3E;
  localparam logic [CHAR_W-1:0] CHAR_COMMENT = 8'h3B;
  localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              end_of_text;
  } item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [PLANE_W-1:0]  plane0_byte;
    logic [PLANE_W-1:0]  plane1_byte;
    logic [OFFSET_W-1:0] base_offset;
    logic                final_item;
  } result_t;

  typedef struct packed {
    logic       is_base;
    logic [1:0] code;
  } base_t;

  // two-bit code of a base character, n packs as a
  function automatic base_t base_code(input logic [CHAR_W-1:0] c);
    base_t b;
    b.is_base = 1'b1;
    b.code    = 2'd0;
    case (c)
      CHAR_A, CHAR_N: b.code = 2'd0;
      CHAR_C:         b.code = 2'd1;
      CHAR_G:         b.code = 2'd2;
      CHAR_T:         b.code = 2'd3;
      default:        b.is_base = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/ftbpp_in_reg.sv -----
// ----------------------------------------------------------------------------
// ftbpp_in_reg
// input register: holds one accepted word until the parse stage takes it
// ----------------------------------------------------------------------------
module ftbpp_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                take,
  input  ftbpp_pkg::item_t    item_in,
  output logic                item_valid,
  output ftbpp_pkg::item_t    item_out
);

  logic             valid_r, valid_nxt;
  ftbpp_pkg::item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign item_valid = valid_r;
  assign item_out   = item_r;

endmodule

// ----- rtl/ftbpp_parse.sv -----
// ----------------------------------------------------------------------------
// ftbpp_parse
// line parser and plane packer: one character per cycle when fired, state held here
// ----------------------------------------------------------------------------
module ftbpp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ftbpp_pkg::item_t    item,
  output logic                has_result,
  output ftbpp_pkg::result_t  result
);

  logic                                at_line_start_r, at_line_start_nxt;
  logic                                line_is_bases_r, line_is_bases_nxt;
  logic [ftbpp_pkg::PLANE_W-1:0]       plane0_r, plane0_nxt;
  logic [ftbpp_pkg::PLANE_W-1:0]       plane1_r, plane1_nxt;
  logic [ftbpp_pkg::FILL_W-1:0]        fill_r, fill_nxt;
  logic [ftbpp_pkg::COUNT_BITS-1:0]    total_r, total_nxt;
  logic                                error_r, error_nxt;

  ftbpp_pkg::base_t                    base;
  logic [ftbpp_pkg::PLANE_W-1:0]       p0_packed, p1_packed;
  logic [ftbpp_pkg::COUNT_BITS-1:0]    total_inc;
  logic                                do_pack, do_error;

  assign base      = ftbpp_pkg::base_code(item.text_char);
  assign p0_packed = plane0_r | (ftbpp_pkg::PLANE_W'(base.code[1]) << fill_r);
  assign p1_packed = plane1_r | (ftbpp_pkg::PLANE_W'(base.code[0]) << fill_r);
  assign total_inc = (total_r == ftbpp_pkg::COUNT_MAX) ? total_r
                                                       : total_r + 1'b1;

  always_comb begin
    at_line_start_nxt = at_line_start_r;
    line_is_bases_nxt = line_is_bases_r;
    plane0_nxt        = plane0_r;
    plane1_nxt        = plane1_r;
    fill_nxt          = fill_r;
    total_nxt         = total_r;
    error_nxt         = error_r;
    do_pack           = 1'b0;
    do_error          = 1'b0;
    has_result        = 1'b0;
    result            = '0;
    result.base_offset = ftbpp_pkg::OFFSET_W'(total_r);

    if (item.end_of_text) begin
      // final word, then back to the reset state
      has_result        = 1'b1;
      result.final_item = 1'b1;
      if (error_r) begin
        result.result_kind = ftbpp_pkg::KIND_ERROR;
      end else begin
        result.result_kind = ftbpp_pkg::KIND_END;
        result.plane0_byte = plane0_r;
        result.plane1_byte = plane1_r;
      end
      at_line_start_nxt = 1'b1;
      line_is_bases_nxt = 1'b0;
      plane0_nxt        = '0;
      plane1_nxt        = '0;
      fill_nxt          = '0;
      total_nxt         = '0;
      error_nxt         = 1'b0;
    end else if (!error_r) begin
      if (at_line_start_r) begin
        at_line_start_nxt = 1'b0;
        if (item.text_char == ftbpp_pkg::CHAR_HEADER) begin
          line_is_bases_nxt  = 1'b0;
          has_result         = 1'b1;
          result.result_kind = ftbpp_pkg::KIND_RECORD;
        end else if (item.text_char == ftbpp_pkg::CHAR_COMMENT) begin
          line_is_bases_nxt = 1'b0;
        end else if (base.is_base) begin
          line_is_bases_nxt = 1'b1;
          do_pack           = 1'b1;
        end else begin
          do_error = 1'b1;
        end
      end else if (item.text_char == ftbpp_pkg::CHAR_LF) begin
        at_line_start_nxt = 1'b1;
        line_is_bases_nxt = 1'b0;
      end else if (line_is_bases_r && item.text_char != ftbpp_pkg::CHAR_CR) begin
        if (base.is_base) begin
          do_pack = 1'b1;
        end else begin
          do_error = 1'b1;
        end
      end
    end

    if (do_error) begin
      error_nxt          = 1'b1;
      has_result         = 1'b1;
      result.result_kind = ftbpp_pkg::KIND_ERROR;
    end

    if (do_pack) begin
      total_nxt = total_inc;
      fill_nxt  = fill_r + 1'b1;
      if (fill_r == {ftbpp_pkg::FILL_W{1'b1}}) begin
        // eighth base closes the byte pair
        has_result         = 1'b1;
        result.result_kind = ftbpp_pkg::KIND_PAIR;
        result.plane0_byte = p0_packed;
        result.plane1_byte = p1_packed;
        result.base_offset = ftbpp_pkg::OFFSET_W'(total_inc);
        plane0_nxt         = '0;
        plane1_nxt         = '0;
      end else begin
        plane0_nxt = p0_packed;
        plane1_nxt = p1_packed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      line_is_bases_r <= 1'b0;
      plane0_r        <= '0;
      plane1_r        <= '0;
      fill_r          <= '0;
      total_r         <= '0;
      error_r         <= 1'b0;
    end else if (fire) begin
      at_line_start_r <= at_line_start_nxt;
      line_is_bases_r <= line_is_bases_nxt;
      plane0_r        <= plane0_nxt;
      plane1_r        <= plane1_nxt;
      fill_r          <= fill_nxt;
      total_r         <= total_nxt;
      error_r         <= error_nxt;
    end
  end

endmodule

// ----- rtl/ftbpp_out_reg.sv -----
// ----------------------------------------------------------------------------
// ftbpp_out_reg
// result register: holds a word until the downstream side takes it
// ----------------------------------------------------------------------------
module ftbpp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                has_result,
  input  ftbpp_pkg::result_t  result_in,
  input  logic                out_stall,
  output logic                out_valid,
  output ftbpp_pkg::result_t  result_out
);

  logic               valid_r, valid_nxt;
  ftbpp_pkg::result_t result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = has_result;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule

// ----- rtl/fasta_two_bit_plane_packer_core.sv -----
// ----------------------------------------------------------------------------
// fasta_two_bit_plane_packer_core
// packs fasta text into two bit planes, eight bases per byte pair
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in_      | input     | in_valid/in_stall  | text_char, end_of_text
//   out_     | output    | out_valid/out_stall| result_kind, plane bytes,
//            |           |                    | base_offset, final_item
//
// one character per clock while the parse stage can fire; an accepted text word is
// held in the input register, and any result word it yields in the result register
// the loop that sets the rate is the parse state update
// synchronous active-low reset clears parse state and both valid flags
// out_stall holds the result register, and the parse stage then holds the
// input register; in_stall rises only when that register is full and blocked
// ----------------------------------------------------------------------------
module fasta_two_bit_plane_packer_core (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ftbpp_pkg::CHAR_W-1:0]      in_text_char,
  input  logic                              in_end_of_text,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_result_kind,
  output logic [ftbpp_pkg::PLANE_W-1:0]     out_plane0_byte,
  output logic [ftbpp_pkg::PLANE_W-1:0]     out_plane1_byte,
  output logic [ftbpp_pkg::OFFSET_W-1:0]    out_base_offset,
  output logic                              out_final_item
);

  ftbpp_pkg::item_t   in_item, held_item;
  ftbpp_pkg::result_t step_result, out_result;
  logic               held_valid;
  logic               fire;
  logic               step_has_result;
  logic               in_load;

  // parse stage advances when it has a word and the result register is free
  assign fire     = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !fire;
  assign in_load  = in_valid && !in_stall;

  assign in_item.text_char   = in_text_char;
  assign in_item.end_of_text = in_end_of_text;

  ftbpp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_load),
    .take       (fire),
    .item_in    (in_item),
    .item_valid (held_valid),
    .item_out   (held_item)
  );

  ftbpp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (held_item),
    .has_result (step_has_result),
    .result     (step_result)
  );

  ftbpp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .has_result (step_has_result),
    .result_in  (step_result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (out_result)
  );

  assign out_result_kind = out_result.result_kind;
  assign out_plane0_byte = out_result.plane0_byte;
  assign out_plane1_byte = out_result.plane1_byte;
  assign out_base_offset = out_result.base_offset;
  assign out_final_item  = out_result.final_item;

endmodule
